[hw/rtl/m64x_pkg.sv]
// Shared types and constants for the MIPS64 integer execute core.
package m64x_pkg;

  localparam int unsigned XLEN = 64;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BREAK    = 3'd1,
    ST_TRAP     = 3'd2,
    ST_OVF      = 3'd3,
    ST_RESERVED = 3'd4,
    ST_OUTSIDE  = 3'd5,
    ST_AWAIT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_READ  = 2'd1,
    MOP_WRITE = 2'd2
  } mem_op_t;

  typedef enum logic [1:0] {
    BK_NONE    = 2'd0,
    BK_BRANCH  = 2'd1,
    BK_DELAY   = 2'd2,
    BK_NULLIFY = 2'd3
  } branch_kind_t;

  localparam logic CFG_START_PC    = 1'b0;
  localparam logic CFG_START_STACK = 1'b1;

  // Entry queued between the accepting front and the execute back end.
  typedef struct packed {
    logic        func;
    logic [31:0] instr;
    logic [31:0] load_word;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_byte_en;
  } rsp_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic lts(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

[hw/rtl/m64x_if.sv]
// Valid/ready channel interfaces for requests and results.
interface m64x_req_if;
  import m64x_pkg::*;
  logic valid;
  logic ready;
  logic        func;
  logic [31:0] instr;
  logic [31:0] load_word;
  modport source (output valid, func, instr, load_word, input ready);
  modport sink (input valid, func, instr, load_word, output ready);
endinterface

interface m64x_rsp_if;
  import m64x_pkg::*;
  logic valid;
  logic ready;
  logic [31:0] next_pc;
  logic [2:0]  status;
  logic [1:0]  mem_op;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_byte_en;
  modport source (output valid, next_pc, status, mem_op, mem_addr, mem_wdata, mem_byte_en,
                  input ready);
  modport sink (input valid, next_pc, status, mem_op, mem_addr, mem_wdata, mem_byte_en,
                output ready);
endinterface

[hw/rtl/m64x_queue.sv]
// Two-entry request queue between front and back.
module m64x_queue import m64x_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t pop_data
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[hw/rtl/m64x_muldiv.sv]
// Iterative 32-bit multiply/divide unit: one bit per cycle.
module m64x_muldiv import m64x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic        is_signed,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res_hi,
  output logic [31:0] res_lo
);
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;     // mul: product; div: {rem, quo}
  logic [31:0] opb_r;
  logic        div_r, negq_r, negr_r, negp_r;
  logic [31:0] ma, mb;
  logic [32:0] trial;
  logic [63:0] sh;
  logic [32:0] addv;
  logic [31:0] q, r;
  logic [63:0] p;

  assign ma = (is_signed && a[31]) ? 32'd0 - a : a;
  assign mb = (is_signed && b[31]) ? 32'd0 - b : b;
  assign sh = {acc_r[62:0], 1'b0};
  // shifted remainder can carry into bit 32 for large unsigned divisors
  assign trial = {acc_r[63], sh[63:32]} - {1'b0, opb_r};
  assign addv = {1'b0, acc_r[63:32]} + {1'b0, (acc_r[0] ? opb_r : 32'd0)};
  assign done = busy_r && cnt_r == 6'd0;
  assign q = negq_r ? 32'd0 - acc_r[31:0] : acc_r[31:0];
  assign r = negr_r ? 32'd0 - acc_r[63:32] : acc_r[63:32];
  assign p = negp_r ? 64'd0 - acc_r : acc_r;
  assign res_hi = div_r ? r : p[63:32];
  assign res_lo = div_r ? q : p[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      div_r  <= is_div;
      opb_r  <= is_div ? mb : (is_signed ? mb : b);
      acc_r  <= {32'd0, is_signed ? ma : a};
      negq_r <= is_signed && (a[31] ^ b[31]);
      negr_r <= is_signed && a[31];
      negp_r <= is_signed && (a[31] ^ b[31]);
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
        if (div_r) begin
          if (!trial[32]) acc_r <= {trial[31:0], sh[31:1], 1'b1};
          else acc_r <= sh;
        end else begin
          acc_r <= {addv, acc_r[31:1]};
        end
      end
    end
  end
endmodule

[hw/rtl/m64x_exec.sv]
// Execute back end: register file, branch state, loads, stores, hi/lo.
module m64x_exec import m64x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        q_empty,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);
  typedef enum logic [1:0] {S_IDLE, S_MD, S_OUT} state_t;

  state_t       state_r;
  logic [63:0]  gpr_r [32];
  logic [63:0]  hi_r, lo_r;
  logic [31:0]  pc_r, btgt_r;
  branch_kind_t bk_r;
  logic         lp_r, started_r;
  logic [2:0]   lk_r;
  logic [4:0]   ld_r;
  logic [1:0]   lo_ff_r;
  rsp_t         rsp_r;
  rsp_t         rsp_nxt;

  // decode
  logic [31:0] op;
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sa, sel;
  logic [63:0] a, b, imm, zimm;
  logic [31:0] a32, b32, tgt, ea, t;
  logic [1:0]  off;

  // effects
  logic         wen;
  logic [4:0]   wa;
  logic [63:0]  wv;
  logic         w31;
  logic [2:0]   st;
  logic [1:0]   mop;
  logic [31:0]  wdata;
  logic [3:0]   ben;
  logic         take, likely, isbr;
  logic [31:0]  brt;
  logic         hi_we, lo_we;
  logic [63:0]  hi_v, lo_v;
  logic         md_go, md_div, md_sgn, md_start;
  logic         ld_go;
  logic [31:0]  npc;
  branch_kind_t nbk;
  logic [31:0]  nbt;
  logic [63:0]  ldv;
  logic [31:0]  oldw, lw, hw, lt;
  logic         md_done;
  logic [31:0]  md_hi, md_lo;
  logic [63:0]  mix;

  assign op   = q_data.instr;
  assign opc  = op[31:26];
  assign fn   = op[5:0];
  assign rs   = op[25:21];
  assign rt   = op[20:16];
  assign rd   = op[15:11];
  assign sa   = op[10:6];
  assign sel  = op[20:16];
  assign a    = gpr_r[rs];
  assign b    = gpr_r[rt];
  assign a32  = a[31:0];
  assign b32  = b[31:0];
  assign imm  = {{48{op[15]}}, op[15:0]};
  assign zimm = {48'd0, op[15:0]};
  assign tgt  = pc_r + 32'd4 + {imm[29:0], 2'b00};
  assign ea   = a32 + imm[31:0];
  assign off  = ea[1:0];

  // start only for an instruction actually executed this cycle
  assign md_start = state_r == S_IDLE && !q_empty && !q_data.func && !lp_r && md_go;

  m64x_muldiv u_md (
    .clk, .rst_n, .start(md_start), .is_div(md_div), .is_signed(md_sgn),
    .a(a32), .b(b32), .done(md_done), .res_hi(md_hi), .res_lo(md_lo)
  );

  always_comb begin
    wen = 1'b0; wa = rd; wv = '0; w31 = 1'b0; st = ST_OK; mop = MOP_NONE;
    wdata = '0; ben = '0; take = 1'b0; likely = 1'b0; isbr = 1'b0; brt = tgt;
    hi_we = 1'b0; lo_we = 1'b0; hi_v = a; lo_v = a; md_go = 1'b0;
    md_div = 1'b0; md_sgn = 1'b0; ld_go = 1'b0; t = '0; mix = '0;
    case (opc)
      6'h00: begin
        wen = 1'b1;
        case (fn)
          6'h00: begin mix = {32'd0, b32} << sa; wv = sx32(mix[31:0]); end
          6'h02: wv = sx32(b32 >> sa);
          6'h03: wv = sx32(32'($signed(b32) >>> sa));
          6'h04: begin mix = {32'd0, b32} << a[4:0]; wv = sx32(mix[31:0]); end
          6'h06: wv = sx32(b32 >> a[4:0]);
          6'h07: wv = sx32(32'($signed(b32) >>> a[4:0]));
          6'h08: begin wen = 1'b0; isbr = 1'b1; take = 1'b1; brt = a32; end
          6'h09: begin isbr = 1'b1; take = 1'b1; brt = a32; wv = sx32(pc_r + 32'd8); end
          6'h0c, 6'h0f: wen = 1'b0;
          6'h0d: begin wen = 1'b0; st = ST_BREAK; end
          6'h10: wv = hi_r;
          6'h11: begin wen = 1'b0; hi_we = 1'b1; end
          6'h12: wv = lo_r;
          6'h13: begin wen = 1'b0; lo_we = 1'b1; end
          6'h14: wv = b << a[5:0];
          6'h16: wv = b >> a[5:0];
          6'h17: wv = $signed(b) >>> a[5:0];
          6'h18: begin wen = 1'b0; md_go = 1'b1; md_sgn = 1'b1; end
          6'h19: begin wen = 1'b0; md_go = 1'b1; end
          6'h1a: begin wen = 1'b0; md_go = b32 != 0; md_div = 1'b1; md_sgn = 1'b1; end
          6'h1b: begin wen = 1'b0; md_go = b32 != 0; md_div = 1'b1; end
          6'h20: begin
            t = a32 + b32; wv = sx32(t);
            if (~(a32[31] ^ b32[31]) & (a32[31] ^ t[31])) st = ST_OVF;
          end
          6'h21: wv = sx32(a32 + b32);
          6'h22: begin
            t = a32 - b32; wv = sx32(t);
            if ((a32[31] ^ b32[31]) & (a32[31] ^ t[31])) st = ST_OVF;
          end
          6'h23: wv = sx32(a32 - b32);
          6'h24: wv = a & b;
          6'h25: wv = a | b;
          6'h26: wv = a ^ b;
          6'h27: wv = ~(a | b);
          6'h2a: wv = {63'd0, lts(a, b)};
          6'h2b: wv = {63'd0, a < b};
          6'h2d: wv = a + b;
          6'h2f: wv = a - b;
          6'h30: begin wen = 1'b0; if (!lts(a, b)) st = ST_TRAP; end
          6'h31: begin wen = 1'b0; if (a >= b) st = ST_TRAP; end
          6'h32: begin wen = 1'b0; if (lts(a, b)) st = ST_TRAP; end
          6'h33: begin wen = 1'b0; if (a < b) st = ST_TRAP; end
          6'h34: begin wen = 1'b0; if (a == b) st = ST_TRAP; end
          6'h36: begin wen = 1'b0; if (a != b) st = ST_TRAP; end
          6'h38: wv = b << sa;
          6'h3a: wv = b >> sa;
          6'h3b: wv = $signed(b) >>> sa;
          6'h3c: wv = b << {1'b1, sa};
          6'h3e: wv = b >> {1'b1, sa};
          6'h3f: wv = $signed(b) >>> {1'b1, sa};
          default: begin wen = 1'b0; st = ST_RESERVED; end
        endcase
      end
      6'h01: begin
        case (sel)
          5'h00, 5'h10: begin isbr = 1'b1; take = a[63]; end
          5'h01, 5'h11: begin isbr = 1'b1; take = !a[63]; end
          5'h02, 5'h12: begin isbr = 1'b1; take = a[63]; likely = 1'b1; end
          5'h03, 5'h13: begin isbr = 1'b1; take = !a[63]; likely = 1'b1; end
          5'h08: if (!lts(a, imm)) st = ST_TRAP;
          5'h09: if (a >= imm) st = ST_TRAP;
          5'h0a: if (lts(a, imm)) st = ST_TRAP;
          5'h0b: if (a < imm) st = ST_TRAP;
          5'h0c: if (a == imm) st = ST_TRAP;
          5'h0e: if (a != imm) st = ST_TRAP;
          default: st = ST_RESERVED;
        endcase
        w31 = isbr && sel[4];
      end
      6'h02, 6'h03: begin
        isbr = 1'b1; take = 1'b1;
        t = pc_r + 32'd4;
        brt = {t[31:28], op[25:0], 2'b00};
        w31 = opc[0];
      end
      6'h04: begin isbr = 1'b1; take = a == b; end
      6'h05: begin isbr = 1'b1; take = a != b; end
      6'h06: begin isbr = 1'b1; take = a == 0 || a[63]; end
      6'h07: begin isbr = 1'b1; take = a != 0 && !a[63]; end
      6'h14: begin isbr = 1'b1; likely = 1'b1; take = a == b; end
      6'h15: begin isbr = 1'b1; likely = 1'b1; take = a != b; end
      6'h16: begin isbr = 1'b1; likely = 1'b1; take = a == 0 || a[63]; end
      6'h17: begin isbr = 1'b1; likely = 1'b1; take = a != 0 && !a[63]; end
      6'h08: begin
        wen = 1'b1; wa = rt; t = ea; wv = sx32(t);
        if (~(a32[31] ^ imm[31]) & (a32[31] ^ t[31])) st = ST_OVF;
      end
      6'h09: begin wen = 1'b1; wa = rt; wv = sx32(ea); end
      6'h0a: begin wen = 1'b1; wa = rt; wv = {63'd0, lts(a, imm)}; end
      6'h0b: begin wen = 1'b1; wa = rt; wv = {63'd0, a < imm}; end
      6'h0c: begin wen = 1'b1; wa = rt; wv = a & zimm; end
      6'h0d: begin wen = 1'b1; wa = rt; wv = a | zimm; end
      6'h0e: begin wen = 1'b1; wa = rt; wv = a ^ zimm; end
      6'h0f: begin wen = 1'b1; wa = rt; wv = {imm[47:0], 16'd0}; end
      6'h19: begin wen = 1'b1; wa = rt; wv = a + imm; end
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27: begin
        ld_go = 1'b1; mop = MOP_READ; st = ST_AWAIT;
      end
      6'h28: begin
        mop = MOP_WRITE; wdata = {24'd0, b32[7:0]} << {off, 3'b000};
        ben = 4'b0001 << off;
      end
      6'h29: begin
        mop = MOP_WRITE; wdata = {16'd0, b32[15:0]} << {off[1], 4'b0000};
        ben = 4'b0011 << {off[1], 1'b0};
      end
      6'h2a: begin
        mop = MOP_WRITE; wdata = b32 >> {~off, 3'b000};
        ben = 4'b1111 >> ~off;
      end
      6'h2b: begin mop = MOP_WRITE; wdata = b32; ben = 4'b1111; end
      6'h2e: begin
        mop = MOP_WRITE; wdata = b32 << {off, 3'b000};
        ben = 4'b1111 << off;
      end
      6'h10, 6'h11, 6'h12, 6'h13, 6'h2f, 6'h31, 6'h32, 6'h35, 6'h36,
      6'h39, 6'h3a, 6'h3d, 6'h3e:
        st = ST_OUTSIDE;
      default: st = ST_RESERVED;
    endcase
  end

  // pc advance including any new branch
  always_comb begin
    nbk = bk_r;
    nbt = btgt_r;
    if (isbr) begin
      if (take) begin nbk = BK_DELAY; nbt = brt; end
      else if (likely) nbk = BK_NULLIFY;
    end
    case (nbk)
      BK_NONE:    npc = pc_r + 32'd4;
      BK_BRANCH:  begin npc = nbt; nbk = BK_NONE; end
      BK_DELAY:   begin npc = pc_r + 32'd4; nbk = BK_BRANCH; end
      BK_NULLIFY: begin npc = pc_r + 32'd8; nbk = BK_NONE; end
      default:    npc = pc_r + 32'd4;
    endcase
  end

  // load completion merge
  always_comb begin
    lw   = q_data.load_word;
    oldw = gpr_r[ld_r][31:0];
    hw   = lw >> {lo_ff_r[1], 4'b0000};
    case (lk_r)
      3'd0: begin lt = lw >> {lo_ff_r, 3'b000}; ldv = {{56{lt[7]}}, lt[7:0]}; end
      3'd1: begin lt = '0; ldv = {{48{hw[15]}}, hw[15:0]}; end
      3'd2: begin
        lt = 32'hffffffff << {~lo_ff_r, 3'b000};
        ldv = sx32((oldw & ~lt) | (lw << {~lo_ff_r, 3'b000}));
      end
      3'd3: begin lt = '0; ldv = sx32(lw); end
      3'd4: begin lt = lw >> {lo_ff_r, 3'b000}; ldv = {56'd0, lt[7:0]}; end
      3'd5: begin lt = '0; ldv = {48'd0, hw[15:0]}; end
      3'd6: begin
        lt = 32'hffffffff >> {lo_ff_r, 3'b000};
        ldv = sx32((oldw & ~lt) | (lw >> {lo_ff_r, 3'b000}));
      end
      default: begin lt = '0; ldv = {32'd0, lw}; end
    endcase
  end

  // result for the request at the queue head
  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.next_pc = pc_r;
    if (!q_data.func) begin
      if (lp_r) begin
        rsp_nxt.status = ST_AWAIT;
      end else if (st != ST_OK && st != ST_AWAIT) begin
        rsp_nxt.status = st;
      end else begin
        rsp_nxt.next_pc     = npc;
        rsp_nxt.status      = st;
        rsp_nxt.mem_op      = mop;
        rsp_nxt.mem_addr    = (mop != MOP_NONE) ? {ea[31:2], 2'b00} : 32'd0;
        rsp_nxt.mem_wdata   = wdata;
        rsp_nxt.mem_byte_en = ben;
      end
    end
  end

  assign q_pop     = state_r == S_IDLE && !q_empty;
  assign rsp_valid = state_r == S_OUT;
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      for (int i = 0; i < 32; i++) gpr_r[i] <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      pc_r      <= '0;
      bk_r      <= BK_NONE;
      btgt_r    <= '0;
      lp_r      <= 1'b0;
      lk_r      <= '0;
      ld_r      <= '0;
      lo_ff_r   <= '0;
      started_r <= 1'b0;
      rsp_r     <= '0;
    end else begin
      // start values land directly until the first request runs
      if (cfg_we && !started_r) begin
        if (cfg_idx == CFG_START_PC) begin
          pc_r <= cfg_wdata;
        end else begin
          gpr_r[29] <= sx32(cfg_wdata);
        end
      end
      case (state_r)
        S_IDLE: if (!q_empty) begin
          started_r <= 1'b1;
          rsp_r     <= rsp_nxt;
          if (q_data.func) begin
            if (lp_r) begin
              lp_r <= 1'b0;
              if (ld_r != 5'd0) gpr_r[ld_r] <= ldv;
            end
            state_r <= S_OUT;
          end else if (lp_r) begin
            state_r <= S_OUT;
          end else if (st != ST_OK && st != ST_AWAIT) begin
            state_r <= S_OUT;
          end else begin
            pc_r   <= npc;
            bk_r   <= nbk;
            btgt_r <= nbt;
            if (wen && wa != 5'd0) gpr_r[wa] <= wv;
            if (w31) gpr_r[31] <= sx32(pc_r + 32'd8);
            if (hi_we) hi_r <= hi_v;
            if (lo_we) lo_r <= lo_v;
            if (ld_go) begin
              lp_r <= 1'b1; lk_r <= opc[2:0]; ld_r <= rt; lo_ff_r <= off;
            end
            state_r <= md_go ? S_MD : S_OUT;
          end
        end
        S_MD: if (md_done) begin
          hi_r <= sx32(md_hi);
          lo_r <= sx32(md_lo);
          state_r <= S_OUT;
        end
        S_OUT: if (rsp_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/mips64_integer_execute_core.sv]
// Top level of the MIPS64 integer execute core.
// A request passes through the queue and then the execute back end, which registers
// the result; multiply and divide with a nonzero divisor also wait on the muldiv unit (one bit per cycle).
// The execute back end handles one request at a time and takes no new one until
// its result is taken.
// Reset (rst_n low, synchronous): registers, hi/lo and pc clear; start_pc and
// start_stack written before the first request load pc and r29 directly.
module mips64_integer_execute_core import m64x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  m64x_req_if.sink    in_req,
  m64x_rsp_if.source  out_rsp
);
  req_t q_in, q_out;
  logic q_full, q_empty, q_pop;
  rsp_t rsp;

  // front: accept requests into the queue
  assign in_req.ready = !q_full;
  assign q_in = '{func: in_req.func, instr: in_req.instr, load_word: in_req.load_word};

  m64x_queue u_q (
    .clk, .rst_n, .push(in_req.valid && !q_full), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  // back: execute and hold result until taken
  m64x_exec u_ex (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .q_empty, .q_data(q_out), .q_pop,
    .rsp_valid(out_rsp.valid), .rsp_ready(out_rsp.ready), .rsp
  );

  assign out_rsp.next_pc     = rsp.next_pc;
  assign out_rsp.status      = rsp.status;
  assign out_rsp.mem_op      = rsp.mem_op;
  assign out_rsp.mem_addr    = rsp.mem_addr;
  assign out_rsp.mem_wdata   = rsp.mem_wdata;
  assign out_rsp.mem_byte_en = rsp.mem_byte_en;
endmodule

[tb/tb_mips64_integer_execute_core.sv]
// Self-checking testbench for the MIPS64 integer execute core.
`timescale 1ns / 1ps

import m64x_pkg::*;

// Tracks architectural state, predicts one response per accepted request and
// checks the responses in order.
class exec_scoreboard;
  logic [63:0]  gpr [32];
  logic [63:0]  hi, lo;
  logic [31:0]  pc, btgt;
  branch_kind_t bk;
  logic         ld_pend;
  logic [2:0]   ld_kind;
  logic [4:0]   ld_dest;
  logic [1:0]   ld_off;
  logic         started;
  logic [31:0]  cfg_pc, cfg_sp;
  rsp_t         expected_rsp [$];
  int           errors;

  function logic [63:0] sx(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function logic slt(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function void clear_state();
    foreach (gpr[i]) gpr[i] = '0;
    gpr[29] = sx(cfg_sp);
    hi = '0; lo = '0;
    pc = cfg_pc; bk = BK_NONE; btgt = '0;
    ld_pend = 0; ld_kind = '0; ld_dest = '0; ld_off = '0;
    started = 0;
  endfunction

  function new();
    cfg_pc = '0; cfg_sp = '0; errors = 0;
    clear_state();
  endfunction

  // Writes only reach live state before the first request.
  function void write_cfg(input logic idx, input logic [31:0] val);
    if (idx == CFG_START_PC) begin
      cfg_pc = val;
      if (!started) pc = val;
    end else begin
      cfg_sp = val;
      if (!started) gpr[29] = sx(val);
    end
  endfunction

  function void wr(input logic [4:0] r, input logic [63:0] v);
    if (r != 0) gpr[r] = v;
  endfunction

  function void set_branch(input logic take, input logic [31:0] tgt, input logic likely);
    if (take) begin
      bk = BK_DELAY; btgt = tgt;
    end else if (likely) begin
      bk = BK_NULLIFY;
    end
  endfunction

  function void fill_load(input logic [31:0] w);
    logic [31:0] old, h, t;
    logic [4:0]  s;
    logic [63:0] v;
    old = gpr[ld_dest][31:0];
    h = (w >> (8 * (ld_off & 2'd2))) & 32'hffff;
    case (ld_kind)
      3'd0: begin t = w >> (8 * ld_off); v = {{56{t[7]}}, t[7:0]}; end
      3'd1: v = {{48{h[15]}}, h[15:0]};
      3'd2: begin
        s = 8 * (3 - ld_off);
        v = sx((old & ~(32'hffffffff << s)) | (w << s));
      end
      3'd3: v = sx(w);
      3'd4: begin t = w >> (8 * ld_off); v = {56'b0, t[7:0]}; end
      3'd5: v = {48'b0, h[15:0]};
      3'd6: begin
        s = 8 * ld_off;
        v = sx((old & ~(32'hffffffff >> s)) | (w >> s));
      end
      default: v = {32'b0, w};
    endcase
    wr(ld_dest, v);
  endfunction

  function status_t exec_special(input logic [31:0] op, input logic [63:0] a,
                                 input logic [63:0] b);
    logic [4:0]  sa, rd;
    logic [31:0] a32, b32, t, ma, mb, q, r;
    logic [63:0] p, pa, pb;
    logic        na, nb;
    sa = op[10:6]; rd = op[15:11]; a32 = a[31:0]; b32 = b[31:0];
    case (op[5:0])
      6'h00: begin t = b32 << sa; wr(rd, sx(t)); end
      6'h02: begin t = b32 >> sa; wr(rd, sx(t)); end
      6'h03: begin t = $signed(b32) >>> sa; wr(rd, sx(t)); end
      6'h04: begin t = b32 << a[4:0]; wr(rd, sx(t)); end
      6'h06: begin t = b32 >> a[4:0]; wr(rd, sx(t)); end
      6'h07: begin t = $signed(b32) >>> a[4:0]; wr(rd, sx(t)); end
      6'h08: set_branch(1, a32, 0);
      6'h09: begin set_branch(1, a32, 0); wr(rd, sx(pc + 32'd8)); end
      6'h0c, 6'h0f: ;
      6'h0d: return ST_BREAK;
      6'h10: wr(rd, hi);
      6'h11: hi = a;
      6'h12: wr(rd, lo);
      6'h13: lo = a;
      6'h14: wr(rd, b << a[5:0]);
      6'h16: wr(rd, b >> a[5:0]);
      6'h17: wr(rd, $signed(b) >>> a[5:0]);
      6'h18: begin
        pa = sx(a32); pb = sx(b32); p = pa * pb;
        lo = sx(p[31:0]); hi = sx(p[63:32]);
      end
      6'h19: begin
        pa = {32'b0, a32}; pb = {32'b0, b32}; p = pa * pb;
        lo = sx(p[31:0]); hi = sx(p[63:32]);
      end
      6'h1a: if (b32 != 0) begin
        na = a32[31]; nb = b32[31];
        ma = na ? -a32 : a32; mb = nb ? -b32 : b32;
        q = ma / mb; r = ma % mb;
        if (na != nb) q = -q;
        if (na) r = -r;
        lo = sx(q); hi = sx(r);
      end
      6'h1b: if (b32 != 0) begin lo = sx(a32 / b32); hi = sx(a32 % b32); end
      6'h20: begin
        t = a32 + b32;
        if ((~(a32 ^ b32) & (a32 ^ t)) >> 31) return ST_OVF;
        wr(rd, sx(t));
      end
      6'h21: wr(rd, sx(a32 + b32));
      6'h22: begin
        t = a32 - b32;
        if (((a32 ^ b32) & (a32 ^ t)) >> 31) return ST_OVF;
        wr(rd, sx(t));
      end
      6'h23: wr(rd, sx(a32 - b32));
      6'h24: wr(rd, a & b);
      6'h25: wr(rd, a | b);
      6'h26: wr(rd, a ^ b);
      6'h27: wr(rd, ~(a | b));
      6'h2a: wr(rd, {63'b0, slt(a, b)});
      6'h2b: wr(rd, {63'b0, a < b});
      6'h2d: wr(rd, a + b);
      6'h2f: wr(rd, a - b);
      6'h30: return !slt(a, b) ? ST_TRAP : ST_OK;
      6'h31: return a >= b ? ST_TRAP : ST_OK;
      6'h32: return slt(a, b) ? ST_TRAP : ST_OK;
      6'h33: return a < b ? ST_TRAP : ST_OK;
      6'h34: return a == b ? ST_TRAP : ST_OK;
      6'h36: return a != b ? ST_TRAP : ST_OK;
      6'h38: wr(rd, b << sa);
      6'h3a: wr(rd, b >> sa);
      6'h3b: wr(rd, $signed(b) >>> sa);
      6'h3c: wr(rd, b << (sa + 6'd32));
      6'h3e: wr(rd, b >> (sa + 6'd32));
      6'h3f: wr(rd, $signed(b) >>> (sa + 6'd32));
      default: return ST_RESERVED;
    endcase
    return ST_OK;
  endfunction

  function status_t exec_regimm(input logic [4:0] sel, input logic [63:0] a,
                                input logic [63:0] imm, input logic [31:0] tgt);
    case (sel)
      5'h00, 5'h10: set_branch(a[63], tgt, 0);
      5'h01, 5'h11: set_branch(!a[63], tgt, 0);
      5'h02, 5'h12: set_branch(a[63], tgt, 1);
      5'h03, 5'h13: set_branch(!a[63], tgt, 1);
      5'h08: return !slt(a, imm) ? ST_TRAP : ST_OK;
      5'h09: return a >= imm ? ST_TRAP : ST_OK;
      5'h0a: return slt(a, imm) ? ST_TRAP : ST_OK;
      5'h0b: return a < imm ? ST_TRAP : ST_OK;
      5'h0c: return a == imm ? ST_TRAP : ST_OK;
      5'h0e: return a != imm ? ST_TRAP : ST_OK;
      default: return ST_RESERVED;
    endcase
    if (sel[4]) gpr[31] = sx(pc + 32'd8);
    return ST_OK;
  endfunction

  function void advance_pc();
    case (bk)
      BK_NONE:   pc = pc + 32'd4;
      BK_BRANCH: begin pc = btgt; bk = BK_NONE; end
      BK_DELAY:  begin pc = pc + 32'd4; bk = BK_BRANCH; end
      default:   begin pc = pc + 32'd8; bk = BK_NONE; end
    endcase
  endfunction

  // Executes one accepted request and queues the response it must produce.
  function void note_request(input req_t req);
    status_t      st;
    mem_op_t      mop;
    logic [31:0]  maddr, wd, op, a32, b32, t, tgt, ea;
    logic [3:0]   ben;
    logic [5:0]   opc;
    logic [4:0]   rs, rt;
    logic [1:0]   off;
    logic [63:0]  a, b, imm, shi, slo;
    logic [63:0]  saved [32];
    branch_kind_t sbk;
    logic [31:0]  stg;
    rsp_t         rsp;
    st = ST_OK; mop = MOP_NONE; maddr = '0; wd = '0; ben = '0;
    started = 1;
    if (req.func) begin
      if (ld_pend) begin
        fill_load(req.load_word);
        ld_pend = 0;
      end
    end else if (ld_pend) begin
      st = ST_AWAIT;
    end else begin
      op = req.instr; opc = op[31:26]; rs = op[25:21]; rt = op[20:16];
      a = gpr[rs]; b = gpr[rt]; imm = {{48{op[15]}}, op[15:0]};
      a32 = a[31:0]; b32 = b[31:0];
      tgt = pc + 32'd4 + (imm[31:0] << 2);
      ea = a32 + imm[31:0]; off = ea[1:0];
      sbk = bk; stg = btgt; shi = hi; slo = lo;
      foreach (gpr[i]) saved[i] = gpr[i];
      case (opc)
        6'h00: st = exec_special(op, a, b);
        6'h01: st = exec_regimm(rt, a, imm, tgt);
        6'h02, 6'h03: begin
          set_branch(1, ((pc + 32'd4) & ~32'h0fffffff) | ({6'b0, op[25:0]} << 2), 0);
          if (opc == 6'h03) gpr[31] = sx(pc + 32'd8);
        end
        6'h04: set_branch(a == b, tgt, 0);
        6'h05: set_branch(a != b, tgt, 0);
        6'h06: set_branch(a == 0 || a[63], tgt, 0);
        6'h07: set_branch(a != 0 && !a[63], tgt, 0);
        6'h08: begin
          t = a32 + imm[31:0];
          if ((~(a32 ^ imm[31:0]) & (a32 ^ t)) >> 31) st = ST_OVF;
          else wr(rt, sx(t));
        end
        6'h09: wr(rt, sx(ea));
        6'h0a: wr(rt, {63'b0, slt(a, imm)});
        6'h0b: wr(rt, {63'b0, a < imm});
        6'h0c: wr(rt, a & {48'b0, op[15:0]});
        6'h0d: wr(rt, a | {48'b0, op[15:0]});
        6'h0e: wr(rt, a ^ {48'b0, op[15:0]});
        6'h0f: wr(rt, imm << 16);
        6'h14: set_branch(a == b, tgt, 1);
        6'h15: set_branch(a != b, tgt, 1);
        6'h16: set_branch(a == 0 || a[63], tgt, 1);
        6'h17: set_branch(a != 0 && !a[63], tgt, 1);
        6'h19: wr(rt, a + imm);
        6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27: begin
          ld_pend = 1; ld_kind = opc[2:0]; ld_dest = rt; ld_off = off;
          mop = MOP_READ; maddr = {ea[31:2], 2'b00}; st = ST_AWAIT;
        end
        6'h28: begin mop = MOP_WRITE; wd = (b32 & 32'hff) << (8 * off); ben = 4'd1 << off; end
        6'h29: begin
          mop = MOP_WRITE; wd = (b32 & 32'hffff) << (8 * (off & 2'd2));
          ben = 4'd3 << (off & 2'd2);
        end
        6'h2a: begin
          mop = MOP_WRITE; wd = b32 >> (8 * (3 - off));
          ben = (5'd1 << (off + 1)) - 5'd1;
        end
        6'h2b: begin mop = MOP_WRITE; wd = b32; ben = 4'hf; end
        6'h2e: begin mop = MOP_WRITE; wd = b32 << (8 * off); ben = 4'hf << off; end
        6'h10, 6'h11, 6'h12, 6'h13, 6'h2f, 6'h31, 6'h32, 6'h35, 6'h36,
        6'h39, 6'h3a, 6'h3d, 6'h3e: st = ST_OUTSIDE;
        default: st = ST_RESERVED;
      endcase
      if (mop == MOP_WRITE) maddr = {ea[31:2], 2'b00};
      if (st != ST_OK && st != ST_AWAIT) begin
        foreach (gpr[i]) gpr[i] = saved[i];
        hi = shi; lo = slo; bk = sbk; btgt = stg;
        mop = MOP_NONE; maddr = '0; wd = '0; ben = '0;
      end else begin
        gpr[0] = '0;
        advance_pc();
      end
    end
    rsp.next_pc = pc; rsp.status = st; rsp.mem_op = mop;
    rsp.mem_addr = maddr; rsp.mem_wdata = wd; rsp.mem_byte_en = ben;
    expected_rsp.push_back(rsp);
  endfunction

  function void cmp_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, actual %h", name, exp, act);
      errors++;
    end
  endfunction

  function void check_result(input rsp_t got);
    rsp_t exp;
    if (expected_rsp.size() == 0) begin
      $error("response with no request outstanding");
      errors++;
      return;
    end
    exp = expected_rsp.pop_front();
    cmp_field("next_pc", exp.next_pc, got.next_pc);
    cmp_field("status", exp.status, got.status);
    cmp_field("mem_op", exp.mem_op, got.mem_op);
    cmp_field("mem_addr", exp.mem_addr, got.mem_addr);
    cmp_field("mem_wdata", exp.mem_wdata, got.mem_wdata);
    cmp_field("mem_byte_en", exp.mem_byte_en, got.mem_byte_en);
  endfunction
endclass

module tb_mips64_integer_execute_core;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 1550;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;
  logic        quiet;        // no idling on either side
  logic        want_data;    // generator issued a load, data should follow
  int          cycles;

  m64x_req_if req_bus();
  m64x_rsp_if rsp_bus();

  exec_scoreboard sb;

  mips64_integer_execute_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_req(req_bus), .out_rsp(rsp_bus)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Watchdog: a hang or a lost response ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Response side: check every taken response, stall ready in random bursts.
  initial begin : rsp_side
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready)
        sb.check_result({rsp_bus.next_pc, rsp_bus.status, rsp_bus.mem_op,
                         rsp_bus.mem_addr, rsp_bus.mem_wdata, rsp_bus.mem_byte_en});
      if (!quiet && stall == 0 && $urandom_range(7) == 0) stall = $urandom_range(1, 9);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sa,
                                        input logic [5:0] fn);
    return {6'h00, rs, rt, rd, sa, fn};
  endfunction

  // Issue one request; valid stays up into the next request unless a gap is drawn.
  task automatic send_req(input req_t req);
    if (!quiet && $urandom_range(5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= req.func;
    req_bus.instr     <= req.instr;
    req_bus.load_word <= req.load_word;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
    sb.note_request(req);
  endtask

  task automatic send_instr(input logic [31:0] w);
    send_req('{func: 1'b0, instr: w, load_word: $urandom});
  endtask

  task automatic send_data(input logic [31:0] w);
    send_req('{func: 1'b1, instr: $urandom, load_word: w});
  endtask

  // One write, then cfg_we drops before the next, so back-to-back writes never collide.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Drain responses before touching configuration.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed instructions over a small register window, loads
  // followed by their data; a little raw noise to hit the odd corners.
  function automatic req_t gen_req();
    logic [5:0]  fn_list [45] = '{6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, 6'h08, 6'h09,
                                  6'h0c, 6'h0d, 6'h0f, 6'h10, 6'h11, 6'h12, 6'h13, 6'h14,
                                  6'h16, 6'h17, 6'h18, 6'h19, 6'h1a, 6'h1b, 6'h20, 6'h21,
                                  6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27, 6'h2a, 6'h2b,
                                  6'h2d, 6'h2f, 6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h36,
                                  6'h38, 6'h3a, 6'h3b, 6'h3c, 6'h3e};
    logic [4:0]  sel_list [16] = '{5'h00, 5'h01, 5'h02, 5'h03, 5'h10, 5'h11, 5'h12, 5'h13,
                                   5'h08, 5'h09, 5'h0a, 5'h0b, 5'h0c, 5'h0e, 5'h05, 5'h1f};
    logic [5:0]  st_list [5] = '{6'h28, 6'h29, 6'h2a, 6'h2b, 6'h2e};
    logic [5:0]  imm_list [9] = '{6'h08, 6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0e, 6'h0f,
                                  6'h19};
    logic [5:0]  br_list [10] = '{6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07, 6'h14, 6'h15,
                                  6'h16, 6'h17};
    logic [5:0]  md_list [6] = '{6'h18, 6'h19, 6'h1a, 6'h1b, 6'h10, 6'h12};
    req_t        r;
    int          roll;
    logic [15:0] imm;
    r.func = 1'b0; r.instr = $urandom; r.load_word = $urandom;
    roll = $urandom_range(99);
    imm = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    if (want_data && roll < 90) begin
      r.func = 1'b1;
      want_data = 1'b0;
    end else if (roll < 5) begin
      r.func = 1'($urandom);
    end else begin
      case ($urandom_range(10))
        0, 1, 2: r.instr = enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                                 fn_list[$urandom_range(44)]);
        3: r.instr = enc_i(6'h01, pick_reg(), sel_list[$urandom_range(15)], imm);
        4, 5: begin
          r.instr = enc_i(6'h20 + 6'($urandom_range(7)), pick_reg(), pick_reg(), imm);
          want_data = 1'b1;
        end
        6: r.instr = enc_i(st_list[$urandom_range(4)], pick_reg(), pick_reg(), imm);
        7: r.instr = enc_i(imm_list[$urandom_range(8)], pick_reg(), pick_reg(), 16'($urandom));
        8: r.instr = enc_i(br_list[$urandom_range(9)], pick_reg(), pick_reg(), imm);
        9: r.instr = enc_r(pick_reg(), pick_reg(), pick_reg(), 5'd0,
                           md_list[$urandom_range(5)]);
        default: r.instr = enc_i(6'h0f, 5'd0, pick_reg(), 16'($urandom));
      endcase
    end
    return r;
  endfunction

  initial begin : stim
    sb = new();
    quiet     = 1'b0;
    want_data = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_START_PC;
    cfg_wdata = '0;
    req_bus.valid     = 1'b0;
    req_bus.func      = 1'b0;
    req_bus.instr     = '0;
    req_bus.load_word = '0;
    rsp_bus.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before the first request these writes land in pc and r29 directly;
    // a negative stack value checks the sign extension.
    write_reg(CFG_START_PC, $urandom & 32'hfffffffc);
    write_reg(CFG_START_STACK, 32'h80000000);

    // Directed part.
    send_instr(enc_i(6'h0f, 5'd0, 5'd1, 16'h8000));          // r1 = most negative word
    send_instr(enc_i(6'h09, 5'd0, 5'd2, 16'hffff));          // r2 = -1
    send_instr(enc_r(5'd1, 5'd1, 5'd3, 5'd0, 6'h20));        // ADD overflow
    send_instr(enc_r(5'd0, 5'd1, 5'd3, 5'd0, 6'h22));        // SUB overflow
    send_instr(enc_i(6'h08, 5'd1, 5'd3, 16'hffff));          // ADDI overflow
    send_instr(enc_r(5'd1, 5'd2, 5'd0, 5'd0, 6'h1a));        // min / -1
    send_instr(enc_r(5'd0, 5'd0, 5'd4, 5'd0, 6'h12));        // MFLO
    send_instr(enc_r(5'd2, 5'd0, 5'd0, 5'd0, 6'h1b));        // divide by zero keeps hi/lo
    send_instr(enc_r(5'd0, 5'd0, 5'd5, 5'd0, 6'h10));        // MFHI
    send_instr(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h0d));        // BREAK
    send_instr(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h34));        // TEQ taken
    send_instr(enc_i(6'h01, 5'd0, 5'h0b, 16'h0001));         // TLTIU taken
    send_instr(enc_i(6'h3f, 5'd0, 5'd0, 16'h0));             // reserved opcode
    send_instr(enc_i(6'h13, 5'd0, 5'd0, 16'h0));             // native call
    send_instr(enc_i(6'h23, 5'd1, 5'd6, 16'h0003));          // LW misaligned
    send_instr(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h00));        // instr while load pending
    send_data(32'hffffffff);
    send_data(32'h12345678);                                 // data with nothing pending
    send_instr(enc_i(6'h22, 5'd0, 5'd7, 16'h0001));          // LWL
    send_data(32'h89abcdef);
    send_instr(enc_i(6'h20, 5'd0, 5'd0, 16'h0003));          // LB into r0
    send_data(32'h80000000);
    send_instr(enc_i(6'h04, 5'd0, 5'd0, 16'h0004));          // BEQ taken
    send_instr(enc_i(6'h05, 5'd1, 5'd0, 16'h0008));          // taken branch in delay slot
    send_instr(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h00));
    send_instr(enc_i(6'h14, 5'd1, 5'd0, 16'h0004));          // likely not taken, nullify
    send_instr(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'h00));
    send_instr(enc_i(6'h2a, 5'd1, 5'd2, 16'h0001));          // SWL
    send_instr(enc_i(6'h2e, 5'd1, 5'd2, 16'h0002));          // SWR
    drain();

    // Random phases; later writes no longer reach pc or r29, still exercised.
    for (int phase = 0; phase < 3; phase++) begin
      write_reg(CFG_START_PC, phase[0] ? 32'h0 : 32'hffffffff);
      write_reg(CFG_START_STACK, phase[0] ? 32'hffffffff : 32'h0);
      quiet = (phase == 2);
      for (int n = 0; n < RAND_ITEMS / 3; n++) send_req(gen_req());
      drain();
    end

    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
